// ----- sv/ida_pkg.sv -----
// Shared constants for the identifier bitmap allocator.
package ida_pkg;

  localparam int ID_W     = 16;
  localparam int CNT_W    = 17;
  localparam int STATUS_W = 2;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [ID_W-1:0]  ID_BASE_RESET = 16'd300;
  localparam logic [CNT_W-1:0] ID_LIMIT      = 17'h10000;

  localparam logic [STATUS_W-1:0] ST_GRANTED      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_ID_BASE = 1'b0;

endpackage

// ----- sv/ida_ffz.sv -----
// Find-first-zero unit over one word of the usage map.
module ida_ffz #(
  parameter int WORD_W = 32,
  parameter int BIT_W  = 5
) (
  input  logic [WORD_W-1:0] word,
  output logic              found,
  output logic [BIT_W-1:0]  idx
);

  // Scan from the top so the lowest zero bit wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        found = 1'b1;
        idx   = BIT_W'(i);
      end
    end
  end

endmodule

// ----- sv/ida_map.sv -----
// Usage map storage: one write port and one registered read port.
module ida_map #(
  parameter int WORDS  = 128,
  parameter int WORD_W = 32,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/id_bitmap_allocator.sv -----
// Top level of the identifier bitmap allocator: sequencer, config register, map and scan unit.
//
// The block hands out identifiers from a map with one bit per entry. Entry i
// stands for id_base + i. A transaction on the input channel (req_type,
// release_id) is either an allocate, which takes the lowest free entry, or a
// release, which frees the entry of release_id. Each input transaction yields
// exactly one output transaction (granted_id, status).
//
// The map sits in a memory of 32-bit words. An allocate reads one word per
// cycle through a shared find-first-zero unit, scanning the leading full
// words in order until it finds a free usable entry or runs out of usable
// words. A release is a single read-modify-write; an out-of-range release
// skips the map and goes straight to its result. in_ready returns the cycle
// after the result is loaded. A finished result waits in the output
// register, and the next item is accepted while it waits.
// After reset a clearing pass writes every map word to free, one word per
// cycle, with in_ready low. id_base resets to 300 and the APB port takes
// writes at any time. When the receiver stalls, the block finishes the next
// item and then stops accepting.
module id_bitmap_allocator
  import ida_pkg::*;
#(
  parameter int ID_COUNT = 4096
) (
  input  logic                clk,
  input  logic                rst,
  // Request channel.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [ID_W-1:0]     release_id,
  // Result channel.
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ID_W-1:0]     granted_id,
  output logic [STATUS_W-1:0] status,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // Map geometry. Small maps use a single power-of-two word.
  localparam int WORD_W = (ID_COUNT >= 32) ? 32 : (2 ** $clog2(ID_COUNT));
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int WORDS  = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W  = ADDR_W + BIT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_DONE
  } state_t;

  state_t state;

  logic [ID_W-1:0]     id_base;
  logic [ADDR_W-1:0]   clr_addr;
  logic [ADDR_W-1:0]   scan_word;
  logic [BIT_W-1:0]    rel_bit;
  logic [ID_W-1:0]     res_id;
  logic [STATUS_W-1:0] res_status;

  // Configuration register. Writes are taken whenever the bus completes one.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_base <= ID_BASE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ID_BASE)) begin
      id_base <= pwdata[ID_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ID_BASE) begin
      prdata = PDATA_W'(id_base);
    end
  end

  // Number of usable entries: entries whose identifier would pass 16 bits
  // are never handed out and count as out of range on release.
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] usable;

  assign room   = ID_LIMIT - {1'b0, id_base};
  assign usable = (CNT_W'(ID_COUNT) < room) ? CNT_W'(ID_COUNT) : room;

  // Release decode straight from the input ports, done in the accept cycle.
  logic [ID_W-1:0]   rel_off;
  logic              rel_in_range;
  logic [ADDR_W-1:0] rel_word;

  assign rel_off      = release_id - id_base;
  assign rel_in_range = (release_id >= id_base) && ({1'b0, rel_off} < usable);
  assign rel_word     = rel_off[IDX_W-1:BIT_W];

  // Map memory and the shared scan unit.
  logic              map_we;
  logic [ADDR_W-1:0] map_waddr;
  logic [WORD_W-1:0] map_wdata;
  logic [ADDR_W-1:0] map_raddr;
  logic [WORD_W-1:0] map_rdata;
  logic              ffz_found;
  logic [BIT_W-1:0]  ffz_idx;

  ida_map #(
    .WORDS  (WORDS),
    .WORD_W (WORD_W),
    .ADDR_W (ADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  ida_ffz #(
    .WORD_W (WORD_W),
    .BIT_W  (BIT_W)
  ) u_ffz (
    .word  (map_rdata),
    .found (ffz_found),
    .idx   (ffz_idx)
  );

  // Scan step: the candidate entry in the current word, and whether any
  // later word still holds usable entries.
  logic [IDX_W-1:0]  cand_idx;
  logic              cand_ok;
  logic [ADDR_W:0]   next_word;
  logic [CNT_W-1:0]  next_start;
  logic              more_words;

  assign cand_idx   = {scan_word, ffz_idx};
  assign cand_ok    = ffz_found && (CNT_W'(cand_idx) < usable);
  assign next_word  = {1'b0, scan_word} + 1'b1;
  assign next_start = CNT_W'({next_word, {BIT_W{1'b0}}});
  assign more_words = next_start < usable;

  logic accept;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // The output register takes a finished result once it is empty or its
  // current transaction is being accepted.
  logic load_out;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  // Memory port control. The read address is chosen so the word needed in
  // the next state arrives with that state.
  always_comb begin
    map_we    = 1'b0;
    map_waddr = scan_word;
    map_wdata = map_rdata;
    map_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
        map_wdata = '0;
      end
      S_IDLE: begin
        map_raddr = (req_type == REQ_RELEASE) ? rel_word : '0;
      end
      S_ALLOC: begin
        map_raddr = next_word[ADDR_W-1:0];
        if (cand_ok) begin
          map_we    = 1'b1;
          map_wdata = map_rdata | (WORD_W'(1) << ffz_idx);
        end
      end
      S_FREE: begin
        map_we    = 1'b1;
        map_wdata = map_rdata & ~(WORD_W'(1) << rel_bit);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      scan_word  <= '0;
      rel_bit    <= '0;
      res_id     <= '0;
      res_status <= ST_GRANTED;
      granted_id <= '0;
      status     <= ST_GRANTED;
    end else begin
      if (load_out) begin
        out_valid  <= 1'b1;
        granted_id <= res_id;
        status     <= res_status;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_id <= '0;
            if (req_type == REQ_ALLOC) begin
              scan_word <= '0;
              state     <= S_ALLOC;
            end else if (rel_in_range) begin
              scan_word <= rel_word;
              rel_bit   <= rel_off[BIT_W-1:0];
              state     <= S_FREE;
            end else begin
              res_status <= ST_OUT_OF_RANGE;
              state      <= S_DONE;
            end
          end
        end
        S_ALLOC: begin
          if (cand_ok) begin
            res_id     <= id_base + ID_W'(cand_idx);
            res_status <= ST_GRANTED;
            state      <= S_DONE;
          end else if (more_words) begin
            scan_word <= next_word[ADDR_W-1:0];
          end else begin
            res_status <= ST_NONE_FREE;
            state      <= S_DONE;
          end
        end
        S_FREE: begin
          res_status <= ST_RELEASED;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Only a granted result carries an identifier.
  a_id_zero_unless_granted: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && (status != ST_GRANTED)) |-> (granted_id == '0)
  ) else $error("nonzero granted_id on a result that is not a grant");

  // The map is being cleared right after reset, so no request is taken.
  a_no_accept_after_reset: assert property (
    @(posedge clk)
    ($past(rst) && !rst) |-> !in_ready
  ) else $error("request accepted before the map was cleared");

  // No result can appear in the cycle right after a request is taken.
  a_min_latency: assert property (
    @(posedge clk) disable iff (rst)
    (accept && !out_valid) |=> !out_valid
  ) else $error("result appeared one cycle after its request");

  // A grant only ever marks an entry that the scan saw as free and usable.
  a_grant_in_range: assert property (
    @(posedge clk) disable iff (rst)
    (state == S_ALLOC && map_we) |-> (ffz_found && (CNT_W'(cand_idx) < usable))
  ) else $error("allocation wrote an entry outside the usable range");

endmodule
